// File: design/tsdf_pkg.sv
// package for the truncated signed distance grid fusion block
// holds action and status codes, cell record type and shared constants
package tsdf_pkg;
  localparam int GridWidthDef  = 16;
  localparam int GridHeightDef = 16;
  localparam int WeightCapDef  = 32;
  localparam logic [14:0] TruncReset = 15'd4096;
  localparam logic signed [15:0] OneQ14 = 16'sd16384;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_EMPTY = 2'd1,
    ACT_READ  = 2'd2,
    ACT_INIT  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NO_GRID = 2'd1,
    ST_DROPPED = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic [7:0]         weight;
    logic               filled;
  } cell_t;
endpackage

// File: design/tsdf_if.sv
// valid/ready channel interfaces for input items, results and configuration
// depends on nothing
interface tsdf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [4:0]  cell_x;
  logic [4:0]  cell_y;
  logic signed [15:0] sample_distance;
  logic [7:0]  frac_x;
  logic [7:0]  frac_y;
  modport source (output valid, action, cell_x, cell_y, sample_distance, frac_x, frac_y,
                  input ready);
  modport sink (input valid, action, cell_x, cell_y, sample_distance, frac_x, frac_y,
                output ready);
endinterface

interface tsdf_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] distance_value;
  logic [5:0]  cell_weight;
  logic        value_valid;
  logic [1:0]  status;
  modport source (output valid, distance_value, cell_weight, value_valid, status,
                  input ready);
  modport sink (input valid, distance_value, cell_weight, value_valid, status,
                output ready);
endinterface

interface tsdf_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: design/tsdf_div.sv
// restoring divider, one quotient bit per cycle, rounds half away from zero
// standalone, takes a magnitude and a sign and gives a signed quotient
module tsdf_div #(
  parameter int NumW = 32,
  parameter int DenW = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            neg,
  input  logic [NumW-1:0] mag,
  input  logic [DenW-1:0] den,
  output logic            done,
  output logic signed [NumW:0] quot
);
  localparam int CntW = $clog2(NumW + 1);
  logic [NumW-1:0] q;
  logic [DenW:0]   rem;
  logic [DenW-1:0] d;
  logic [CntW-1:0] cnt;
  logic            busy, sgn;
  logic [DenW:0]   trial;

  assign trial = {rem[DenW-1:0], q[NumW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // last quotient bit lands on the edge that raises done
      done <= busy && (cnt == CntW'(1));
      if (start) begin
        busy <= 1'b1;
        q    <= mag + NumW'({1'b0, den[DenW-1:1]});
        rem  <= '0;
        d    <= den;
        sgn  <= neg;
        cnt  <= CntW'(NumW);
      end else if (busy) begin
        if (trial >= {1'b0, d}) begin
          rem <= trial - {1'b0, d};
          q   <= {q[NumW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NumW-2:0], 1'b0};
        end
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) busy <= 1'b0;
      end
    end
  end

  assign quot = sgn ? -$signed({1'b0, q}) : $signed({1'b0, q});
endmodule

// File: design/tsdf_store.sv
// cell memory: one synchronous write port, one registered read port
// depends on tsdf_pkg for the cell record
module tsdf_store import tsdf_pkg::*; #(
  parameter int Depth = 324
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  cell_t                    wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output cell_t                    rdata
);
  cell_t mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: design/tsdf_grid_fusion.sv
// truncated signed distance grid fusion, top level with sequencer, one item at a time
// add: a dropped item returns the cell as it is, else the scaled sample is written into an empty
// cell or averaged into a filled one (up to two 40-step divisions); read: four taps, each a memory
// read then one multiply-accumulate; initialise: one cell per cycle; mark emptiness: each empty
// interior cell is written directly, each filled one averaged; next item taken once the result is taken
// rst clears control, pending weight, grid ready and sets truncation to 4096
module tsdf_grid_fusion import tsdf_pkg::*; #(
  parameter int GridWidth  = GridWidthDef,
  parameter int GridHeight = GridHeightDef,
  parameter int WeightCap  = WeightCapDef
) (
  input logic clk,
  input logic rst,
  tsdf_in_if.sink    in_ch,
  tsdf_out_if.source out_ch,
  tsdf_cfg_if.sink   cfg_ch
);
  localparam int Cols  = GridWidth + 2;
  localparam int Rows  = GridHeight + 2;
  localparam int Cells = Rows * Cols;
  localparam int AW    = $clog2(Cells);
  localparam int CW    = $clog2(Cols + 1);
  localparam int RW    = $clog2(Rows + 1);
  localparam int NumW  = 40;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_INIT   = 12'b000000000010,
    S_RD     = 12'b000000000100,
    S_CELL   = 12'b000000001000,
    S_SCALE  = 12'b000000010000,
    S_SWAIT  = 12'b000000100000,
    S_FUSE   = 12'b000001000000,
    S_FMUL   = 12'b000010000000,
    S_FWAIT  = 12'b000100000000,
    S_WB     = 12'b001000000000,
    S_RACC   = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_t;

  state_t state;
  logic [14:0] trunc;
  logic [5:0]  pend_w;
  logic        grid_ready;

  // latched item
  action_t act;
  logic [CW-1:0] cx;
  logic [RW-1:0] cy;
  logic signed [15:0] samp;
  logic [7:0] fx, fy;

  // sweep / address
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [1:0]    tap;
  cell_t         cur_cell, rd;
  logic signed [15:0] t;
  logic [7:0]    wcap;
  logic signed [NumW-1:0] prod;
  logic signed [33:0] acc;
  logic signed [34:0] tap_prod;
  logic          all_filled;
  logic [5:0]    w_a;

  // memory
  logic    we;
  logic [AW-1:0] waddr, raddr;
  cell_t   wdata;

  tsdf_store #(.Depth(Cells)) u_store (
    .clk, .we, .waddr, .wdata, .raddr, .rdata(rd)
  );

  // writes land on every edge in the clearing state and on the edge that leaves the write-back state
  assign we = (state == S_INIT) || (state == S_WB);

  // divider
  logic div_start, div_neg, div_done;
  logic [NumW-1:0] div_mag;
  logic [15:0] div_den;
  logic signed [NumW:0] div_q;
  tsdf_div #(.NumW(NumW), .DenW(16)) u_div (
    .clk, .rst, .start(div_start), .neg(div_neg), .mag(div_mag),
    .den(div_den), .done(div_done), .quot(div_q)
  );

  // result register
  logic signed [15:0] o_val;
  logic [5:0] o_w;
  logic o_vv;
  status_t o_st;
  logic o_valid;

  assign out_ch.valid          = o_valid;
  assign out_ch.distance_value = o_val;
  assign out_ch.cell_weight    = o_w;
  assign out_ch.value_valid    = o_vv;
  assign out_ch.status         = o_st;
  assign in_ch.ready  = (state == S_IDLE) && !o_valid;
  assign cfg_ch.ready = 1'b1;

  // read address of the next tap for bilinear read
  logic [1:0]    ntap;
  logic [RW-1:0] trow;
  logic [CW-1:0] tcol;
  assign ntap = tap + 2'd1;
  always_comb begin
    trow = ntap[0] ? cy : cy + RW'(1);
    tcol = ntap[1] ? cx + CW'(2) : cx + CW'(1);
  end

  // fused weight
  logic [7:0] w_inc;
  assign w_inc = cur_cell.weight + 8'd1;

  // running-average numerator, value times capped weight less one plus new value
  assign prod = NumW'(cur_cell.value * $signed({1'b0, wcap - 8'd1})) + NumW'(t);

  // bilinear coefficient for current tap
  logic [8:0] cyw, cxw;
  assign cyw = tap[0] ? {1'b0, fy} : 9'd256 - {1'b0, fy};
  assign cxw = tap[1] ? {1'b0, fx} : 9'd256 - {1'b0, fx};
  logic [17:0] coef;
  always_ff @(posedge clk) coef <= cyw * cxw;

  // signed tap contribution, coefficient kept positive
  assign tap_prod = $signed({1'b0, coef}) * cur_cell.value;

  logic is_sweep;
  assign is_sweep = (act == ACT_EMPTY);

  always_ff @(posedge clk) begin
    if (rst) trunc <= TruncReset;
    else if (cfg_ch.valid && cfg_ch.ready) trunc <= cfg_ch.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend_w <= '0;
      grid_ready <= 1'b0;
      o_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) o_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            act  <= action_t'(in_ch.action);
            cx   <= CW'(in_ch.cell_x);
            cy   <= RW'(in_ch.cell_y);
            samp <= in_ch.sample_distance;
            fx   <= in_ch.frac_x;
            fy   <= in_ch.frac_y;
            o_val <= '0; o_w <= '0; o_vv <= 1'b0;
            tap <= '0;
            acc <= '0;
            all_filled <= 1'b1;
            unique case (action_t'(in_ch.action))
              ACT_INIT: begin
                o_st <= ST_DONE;
                if (!grid_ready) begin
                  waddr <= '0;
                  wdata <= '{value: '0, weight: {2'b00, pend_w}, filled: 1'b0};
                  state <= S_INIT;
                end else state <= S_OUT;
              end
              ACT_EMPTY: begin
                o_st <= ST_DONE;
                if (grid_ready) begin
                  row <= RW'(1); col <= CW'(1);
                  raddr <= AW'(Cols + 1);
                  waddr <= AW'(Cols + 1);
                  state <= S_RD;
                end else begin
                  if (pend_w < 6'(WeightCap)) pend_w <= pend_w + 6'd1;
                  state <= S_OUT;
                end
              end
              default: begin
                if (!grid_ready) begin
                  o_st <= ST_NO_GRID;
                  state <= S_OUT;
                end else if (action_t'(in_ch.action) == ACT_ADD) begin
                  if (in_ch.cell_x > 5'(Cols - 1) || in_ch.cell_y > 5'(Rows - 1)) begin
                    o_st <= ST_RANGE;
                    state <= S_OUT;
                  end else begin
                    o_st <= ST_DONE;
                    raddr <= AW'(in_ch.cell_y * Cols + in_ch.cell_x);
                    waddr <= AW'(in_ch.cell_y * Cols + in_ch.cell_x);
                    state <= S_RD;
                  end
                end else begin
                  if (6'(in_ch.cell_x) + 6'd2 > 6'(Cols - 1) ||
                      6'(in_ch.cell_y) + 6'd1 > 6'(Rows - 1)) begin
                    o_st <= ST_RANGE;
                    state <= S_OUT;
                  end else begin
                    o_st <= ST_DONE;
                    raddr <= AW'((in_ch.cell_y + 1) * Cols + in_ch.cell_x + 1);
                    state <= S_RD;
                  end
                end
              end
            endcase
          end
        end
        S_INIT: begin
          if (waddr == AW'(Cells - 1)) begin
            grid_ready <= 1'b1;
            state <= S_OUT;
          end else waddr <= waddr + AW'(1);
        end
        S_RD: state <= S_CELL;
        S_CELL: begin
          cur_cell <= rd;
          if (act == ACT_READ) begin
            if (tap == 2'd0) w_a <= rd.weight[5:0];
            if (!rd.filled) all_filled <= 1'b0;
            state <= S_RACC;
          end else if (is_sweep) begin
            t <= OneQ14;
            state <= S_FUSE;
          end else if ($signed({samp[15], samp}) < -$signed({2'b00, trunc})) begin
            o_val <= rd.value; o_w <= rd.weight[5:0]; o_vv <= rd.filled;
            o_st <= ST_DROPPED;
            state <= S_OUT;
          end else if (trunc == '0 || samp[15]) begin
            if (trunc == '0) begin
              t <= OneQ14;
              state <= S_FUSE;
            end else begin
              div_start <= 1'b1;
              div_neg <= 1'b1;
              div_mag <= NumW'(-{{16{samp[15]}}, samp}) << 14;
              div_den <= {1'b0, trunc};
              state <= S_SWAIT;
            end
          end else begin
            div_start <= 1'b1;
            div_neg <= 1'b0;
            div_mag <= NumW'({16'b0, samp}) << 14;
            div_den <= {1'b0, trunc};
            state <= S_SWAIT;
          end
        end
        S_SWAIT: begin
          div_start <= 1'b0;
          if (div_done) begin
            t <= (div_q > 41'sd16384) ? OneQ14 : 16'(div_q);
            state <= S_FUSE;
          end
        end
        S_FUSE: begin
          if (!cur_cell.filled) begin
            wdata <= '{value: t, weight: w_inc, filled: 1'b1};
            state <= S_WB;
          end else begin
            wcap <= (w_inc > 8'(WeightCap)) ? 8'(WeightCap) : w_inc;
            state <= S_FMUL;
          end
        end
        S_FMUL: begin
          div_start <= 1'b1;
          div_neg <= prod[NumW-1];
          div_mag <= prod[NumW-1] ? -prod : prod;
          div_den <= {8'b0, wcap};
          state <= S_FWAIT;
        end
        S_FWAIT: begin
          div_start <= 1'b0;
          if (div_done) begin
            wdata <= '{value: 16'(div_q), weight: wcap, filled: 1'b1};
            state <= S_WB;
          end
        end
        S_WB: begin
          if (is_sweep) begin
            if (col == CW'(GridWidth)) begin
              col <= CW'(1);
              if (row == RW'(GridHeight)) state <= S_OUT;
              else begin
                row <= row + RW'(1);
                raddr <= AW'((row + RW'(1)) * Cols + 1);
                waddr <= AW'((row + RW'(1)) * Cols + 1);
                state <= S_RD;
              end
            end else begin
              col <= col + CW'(1);
              raddr <= waddr + AW'(1);
              waddr <= waddr + AW'(1);
              state <= S_RD;
            end
          end else begin
            o_val <= wdata.value; o_w <= wdata.weight[5:0]; o_vv <= 1'b1;
            state <= S_OUT;
          end
        end
        S_RACC: begin
          acc <= acc + tap_prod[33:0];
          if (tap == 2'd3) begin
            state <= S_OUT;
            o_w <= w_a;
          end else begin
            tap <= ntap;
            raddr <= AW'(trow * Cols + tcol);
            state <= S_RD;
          end
        end
        S_OUT: begin
          if (act == ACT_READ && o_st == ST_DONE) begin
            o_vv <= all_filled;
            o_val <= all_filled ? 16'((acc + (acc[33] ? 34'sd32767 : 34'sd32768)) >>> 16)
                                : '0;
          end
          o_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // sweep indices never fall below the first interior row and column
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WB && is_sweep) |-> (row >= RW'(1) && col >= CW'(1)))
    else $error("sweep outside interior");
  // a waiting result stays raised until it is taken
  assert property (@(posedge clk) disable iff (rst)
    (o_valid && !out_ch.ready) |=> o_valid)
    else $error("result dropped");
  // no item accepted unless idle
  assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |-> (state == S_IDLE))
    else $error("item taken while busy");
endmodule
